// File: hdl/analog_dial_digit_reader_assert.svh
// Assertion macros for the analog dial digit reader.
// Needs clk and rst in the scope of the module that includes it.
`ifndef ANALOG_DIAL_DIGIT_READER_ASSERT_SVH
`define ANALOG_DIAL_DIGIT_READER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define ADR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define ADR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/adr_pkg.sv
// Shared types, constants and the CORDIC angle table of the dial digit reader.
// No dependencies.
package adr_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int ANGLE_BITS   = 16;
  localparam int TABLE_LEN    = 24;
  localparam int NUM_CELLS    = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
  localparam int XW           = 26;   // datapath width of the CORDIC vector
  localparam int SHW          = 5;    // bits of a cell's shift amount
  localparam int T10W         = ANGLE_BITS + 4;

  typedef struct packed {
    logic signed [15:0] sin_part;
    logic signed [15:0] cos_part;
    logic               first_dial;
    logic [3:0]         meter_id;
  } adr_in_t;

  typedef struct packed {
    logic [3:0] digit;
    logic       is_tenths;
    logic [3:0] meter_out;
    logic       last_of_run;
  } adr_out_t;

  typedef struct packed {
    logic                 valid;
    logic                 zero;
    logic                 first;
    logic [3:0]           meter;
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic [31:0]          z;
  } adr_cell_t;

  typedef struct packed {
    logic            valid;
    logic            first;
    logic [3:0]      meter;
    logic [T10W-1:0] t10;
  } adr_tail_t;

  // atan(2^-i) as a fraction of a turn, scaled by 2^32.
  function automatic logic [31:0] turn_angle(input logic [SHW-1:0] idx);
    logic [31:0] a;
    case (idx)
      5'd0:  a = 32'h20000000;
      5'd1:  a = 32'h12E4051E;
      5'd2:  a = 32'h09FB385B;
      5'd3:  a = 32'h051111D4;
      5'd4:  a = 32'h028B0D43;
      5'd5:  a = 32'h0145D7E1;
      5'd6:  a = 32'h00A2F61E;
      5'd7:  a = 32'h00517C55;
      5'd8:  a = 32'h0028BE53;
      5'd9:  a = 32'h00145F2F;
      5'd10: a = 32'h000A2F98;
      5'd11: a = 32'h000517CC;
      5'd12: a = 32'h00028BE6;
      5'd13: a = 32'h000145F3;
      5'd14: a = 32'h0000A2F9;
      5'd15: a = 32'h0000517C;
      5'd16: a = 32'h000028BE;
      5'd17: a = 32'h0000145F;
      5'd18: a = 32'h00000A2F;
      5'd19: a = 32'h00000517;
      5'd20: a = 32'h0000028B;
      5'd21: a = 32'h00000145;
      5'd22: a = 32'h000000A2;
      5'd23: a = 32'h00000051;
      default: a = 32'h00000000;
    endcase
    return a;
  endfunction

endpackage

// File: hdl/adr_cell.sv
// One vectoring CORDIC step of the dial digit reader, registered.
// Depends on adr_pkg.
module adr_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      advance,
  input  logic [adr_pkg::SHW-1:0]   shift,
  input  logic [31:0]               angle,
  input  adr_pkg::adr_cell_t        cell_in,
  output adr_pkg::adr_cell_t        cell_out
);
  import adr_pkg::*;

  logic signed [XW-1:0] xs;
  logic signed [XW-1:0] ys;
  adr_cell_t            step;

  always_comb begin
    xs   = $signed(cell_in.x) >>> shift;
    ys   = $signed(cell_in.y) >>> shift;
    step = cell_in;
    // rotate toward the x axis
    if ($signed(cell_in.y) > $signed(XW'(0))) begin
      step.x = cell_in.x + ys;
      step.y = cell_in.y - xs;
      step.z = cell_in.z + angle;
    end else begin
      step.x = cell_in.x - ys;
      step.y = cell_in.y + xs;
      step.z = cell_in.z - angle;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_out.valid <= 1'b0;
    end else if (advance) begin
      cell_out.valid <= cell_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      cell_out.zero  <= step.zero;
      cell_out.first <= step.first;
      cell_out.meter <= step.meter;
      cell_out.x     <= step.x;
      cell_out.y     <= step.y;
      cell_out.z     <= step.z;
    end
  end

endmodule

// File: hdl/adr_emit.sv
// Digit decision, previous-digit state and two-word output buffer.
// Depends on adr_pkg.
module adr_emit (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  adr_pkg::adr_tail_t tail,
  input  logic               ext,
  output logic               free,
  output logic               out_valid,
  input  logic               out_ready,
  output adr_pkg::adr_out_t  out_data
);
  import adr_pkg::*;

  logic [3:0]      previous_digit;
  logic [1:0]      cnt;
  adr_out_t        res0;
  adr_out_t        res1;

  logic [3:0]      whole;
  logic [T10W-1:0] frac_x10;
  logic [3:0]      tenths;
  logic [T10W-1:0] rnd_sum;
  logic [3:0]      rounded;
  logic            corr;
  logic [3:0]      fixed;

  always_comb begin
    whole    = tail.t10[T10W-1:ANGLE_BITS];
    frac_x10 = T10W'(tail.t10[ANGLE_BITS-1:0]) * T10W'(10);
    tenths   = frac_x10[T10W-1:ANGLE_BITS];
    rnd_sum  = tail.t10 + (T10W'(1) << (ANGLE_BITS - 1));
    rounded  = rnd_sum[T10W-1:ANGLE_BITS];
    // not yet past the previous digit: correct one down
    if (tenths >= 4'd5) begin
      corr = {1'b0, tenths} < ({1'b0, previous_digit} + 5'd5);
    end else begin
      corr = ({1'b0, tenths} + 5'd5) < {1'b0, previous_digit};
    end
    if (corr) begin
      fixed = (rounded == 4'd0) ? 4'd9 : rounded - 4'd1;
    end else begin
      fixed = (rounded == 4'd10) ? 4'd0 : rounded;
    end
  end

  assign free      = (cnt == 2'd0);
  assign out_valid = (cnt != 2'd0);
  assign out_data  = res0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt            <= 2'd0;
      previous_digit <= 4'd0;
    end else if (load) begin
      if (tail.first) begin
        previous_digit <= whole;
        cnt            <= ext ? 2'd2 : 2'd1;
      end else begin
        previous_digit <= fixed;
        cnt            <= 2'd1;
      end
    end else if (out_valid && out_ready) begin
      cnt <= cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res1 <= '{digit: tenths, is_tenths: 1'b1, meter_out: tail.meter, last_of_run: 1'b1};
      if (tail.first) begin
        res0 <= '{digit: whole, is_tenths: 1'b0, meter_out: tail.meter,
                  last_of_run: !ext};
      end else begin
        res0 <= '{digit: fixed, is_tenths: 1'b0, meter_out: tail.meter,
                  last_of_run: 1'b1};
      end
    end else if (out_valid && out_ready) begin
      res0 <= res1;
    end
  end

endmodule

// File: hdl/analog_dial_digit_reader.sv
// Top level of the analog dial digit reader: entry stage, CORDIC cell row,
// angle tail stage and digit emitter. Depends on adr_pkg, adr_cell, adr_emit.
//
//   channel  | signals                         | word
//   ---------+---------------------------------+-----------------------------
//   input    | in_valid, in_ready, in_data     | adr_in_t, one dial
//   output   | out_valid, out_ready, out_data  | adr_out_t, one or two digits
//   config   | wr_en, wr_data                  | extended_resolution bit
//
// One dial word at a time walks the row of NUM_CELLS CORDIC cells; the
// input takes a new word once the entry stage, every cell and the tail are
// empty, so it takes no new dial until the last one has left the tail.
// A stalled output holds the whole row in place.
// Reset is synchronous and clears the valid bits, the output count and the
// previous digit; extended_resolution resets to 0.
module analog_dial_digit_reader (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  adr_pkg::adr_in_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output adr_pkg::adr_out_t out_data,
  input  logic             wr_en,
  input  logic             wr_data
);
  import adr_pkg::*;

  `include "analog_dial_digit_reader_assert.svh"

  logic              ext;
  logic              advance;
  logic              busy;
  logic              accept;
  logic              emit_free;
  logic              emit_load;
  adr_cell_t         chain [NUM_CELLS+1];   // chain[0] is the entry stage
  adr_tail_t         tail;
  logic [NUM_CELLS:0] chain_valid;

  // Entry operands: scale by 2^8, turn by half a turn when cos is negative.
  logic signed [XW-1:0] x0;
  logic signed [XW-1:0] y0;
  logic                 flip;

  // Tail operands: round the angle to ANGLE_BITS bits and scale by ten.
  logic [31:0]           z_rnd;
  logic [ANGLE_BITS-1:0] t;
  logic [T10W-1:0]       t10;

  // Hold the mode bit; the user must write it only while idle, which the block does not enforce.
  always_ff @(posedge clk) begin
    if (rst) begin
      ext <= 1'b0;
    end else if (wr_en) begin
      ext <= wr_data;
    end
  end

  always_comb begin
    for (int k = 0; k <= NUM_CELLS; k++) begin
      chain_valid[k] = chain[k].valid;
    end
  end

  assign busy      = (|chain_valid) | tail.valid;
  assign in_ready  = !busy;
  assign accept    = in_valid && in_ready;
  // Stall the row only when the tail holds a dial the emitter cannot take.
  assign emit_load = tail.valid && emit_free;
  assign advance   = !tail.valid || emit_free;

  always_comb begin
    flip = in_data.cos_part[15];
    x0   = {{(XW-24){in_data.cos_part[15]}}, in_data.cos_part, 8'd0};
    y0   = {{(XW-24){in_data.sin_part[15]}}, in_data.sin_part, 8'd0};
    if (flip) begin
      x0 = -x0;
      y0 = -y0;
    end
  end

  // Entry stage: load on accept, drop into the first cell on advance.
  always_ff @(posedge clk) begin
    if (rst) begin
      chain[0].valid <= 1'b0;
    end else if (accept) begin
      chain[0].valid <= 1'b1;
    end else if (advance) begin
      chain[0].valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      chain[0].zero  <= (in_data.sin_part == 16'sd0) && (in_data.cos_part == 16'sd0);
      chain[0].first <= in_data.first_dial;
      chain[0].meter <= in_data.meter_id;
      chain[0].x     <= x0;
      chain[0].y     <= y0;
      chain[0].z     <= flip ? 32'h8000_0000 : 32'h0000_0000;
    end
  end

  // Row of CORDIC cells, one step each.
  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    adr_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .advance  (advance),
      .shift    (SHW'(i)),
      .angle    (turn_angle(SHW'(i))),
      .cell_in  (chain[i]),
      .cell_out (chain[i+1])
    );
  end

  always_comb begin
    z_rnd = chain[NUM_CELLS].z + (32'd1 << (31 - ANGLE_BITS));
    t     = chain[NUM_CELLS].zero ? '0 : z_rnd[31:32-ANGLE_BITS];
    t10   = (T10W'(t) << 3) + (T10W'(t) << 1);
  end

  // Tail stage: advance with the row, clear once the emitter takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      tail.valid <= 1'b0;
    end else if (advance) begin
      tail.valid <= chain[NUM_CELLS].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      tail.first <= chain[NUM_CELLS].first;
      tail.meter <= chain[NUM_CELLS].meter;
      tail.t10   <= t10;
    end
  end

  adr_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .load      (emit_load),
    .tail      (tail),
    .ext       (ext),
    .free      (emit_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Only one dial may travel the row at a time.
  `ADR_ASSERT_NOW(a_one_in_row, 1'b1, $countones({chain_valid, tail.valid}) <= 1,
    "more than one dial in the cell row")
  // An accepted word shows up in the entry stage.
  `ADR_ASSERT_NEXT(a_accept_enters, accept, chain[0].valid && busy,
    "accepted dial did not enter the row")
  // Digits stay decimal.
  `ADR_ASSERT_NOW(a_digit_range, out_valid, out_data.digit <= 4'd9,
    "digit out of decimal range")
  // A tenths digit always closes its run.
  `ADR_ASSERT_NOW(a_tenths_last, out_valid && out_data.is_tenths, out_data.last_of_run,
    "tenths digit not marked last")

endmodule
